// File: rtl/pat_pkg.sv
package pat_pkg;

  localparam int NumProcesses    = 8;
  localparam int PagesPerProcess = 256;
  localparam int FrameSlots      = 64;

  localparam logic [3:0]  MaxLog2     = 4'd12;
  localparam logic [15:0] LfsrSeed    = 16'hACE1;
  localparam logic [3:0]  PageLog2Rst = 4'd8;
  localparam logic [6:0]  FramesRst   = 7'd64;

  typedef enum logic [1:0] {
    CFG_PAGE_LOG2 = 2'd0,
    CFG_REPL_MODE = 2'd1,
    CFG_FRAMES    = 2'd2,
    CFG_NONE      = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LOOK, ST_LOOK_WAIT, ST_FREE_SCAN, ST_VICTIM,
    ST_FIFO_SCAN, ST_FIFO_LAST, ST_MOD_WAIT, ST_VREAD, ST_EVICT, ST_COMMIT, ST_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic clear_step;
    logic pt_read;
    logic scan_start;
    logic scan_step;
    logic pick_random;
    logic rand_load;
    logic fifo_pick;
    logic own_read;
    logic evict;
    logic commit;
    logic out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic addr_err;
    logic pt_present;
    logic free_found;
    logic scan_last;
    logic mod_busy;
  } dp_sts_t;

endpackage

// File: rtl/pat_if.sv
interface pat_access_if;
  logic        valid;
  logic        ready;
  logic [2:0]  process_id;
  logic [19:0] virtual_address;
  logic [31:0] access_time;
  modport source (output valid, process_id, virtual_address, access_time, input ready);
  modport sink (input valid, process_id, virtual_address, access_time, output ready);
endinterface

interface pat_result_if;
  logic        valid;
  logic        ready;
  logic        page_hit;
  logic [17:0] physical_address;
  logic [5:0]  frame_number;
  logic        victim_valid;
  logic [2:0]  victim_process;
  logic [7:0]  victim_page;
  logic        address_error;
  logic [31:0] hit_count;
  logic [31:0] fault_count;
  modport source (output valid, page_hit, physical_address, frame_number, victim_valid,
                  victim_process, victim_page, address_error, hit_count, fault_count,
                  input ready);
  modport sink (input valid, page_hit, physical_address, frame_number, victim_valid,
                victim_process, victim_page, address_error, hit_count, fault_count,
                output ready);
endinterface

interface pat_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/pat_ctrl.sv
module pat_ctrl import pat_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  logic    repl_mode_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:     if (sts_i.clear_done) state_d = ST_IDLE;
      ST_IDLE:      if (in_valid_i) state_d = ST_LOOK;
      ST_LOOK:      state_d = sts_i.addr_err ? ST_OUT : ST_LOOK_WAIT;
      ST_LOOK_WAIT: state_d = sts_i.pt_present ? ST_OUT : ST_FREE_SCAN;
      ST_FREE_SCAN: begin
        if (sts_i.free_found) state_d = ST_COMMIT;
        else if (sts_i.scan_last) state_d = ST_VICTIM;
      end
      ST_VICTIM:    state_d = repl_mode_i ? ST_MOD_WAIT : ST_FIFO_SCAN;
      ST_FIFO_SCAN: if (sts_i.scan_last) state_d = ST_FIFO_LAST;
      ST_FIFO_LAST: state_d = ST_VREAD;
      ST_MOD_WAIT:  if (!sts_i.mod_busy) state_d = ST_VREAD;
      ST_VREAD:     state_d = ST_EVICT;
      ST_EVICT:     state_d = ST_COMMIT;
      ST_COMMIT:    state_d = ST_OUT;
      ST_OUT:       if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:      state_d = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR:     cmd_o.clear_step = 1'b1;
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_LOOK:      cmd_o.pt_read = 1'b1;
      ST_LOOK_WAIT: cmd_o.scan_start = 1'b1;
      ST_FREE_SCAN: cmd_o.scan_step = 1'b1;
      ST_VICTIM: begin
        cmd_o.pick_random = repl_mode_i;
        cmd_o.scan_start  = !repl_mode_i;
      end
      ST_FIFO_SCAN: cmd_o.scan_step = 1'b1;
      ST_FIFO_LAST: cmd_o.fifo_pick = 1'b1;
      ST_MOD_WAIT:  cmd_o.rand_load = !sts_i.mod_busy;
      ST_VREAD:     cmd_o.own_read = 1'b1;
      ST_EVICT:     cmd_o.evict = 1'b1;
      ST_COMMIT:    cmd_o.commit = 1'b1;
      ST_OUT:       cmd_o.out_load = !out_valid_q || out_ready_i;
      default:      cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/pat_dpath.sv
module pat_dpath import pat_pkg::*; #(
  parameter int NUM_PROCESSES     = NumProcesses,
  parameter int PAGES_PER_PROCESS = PagesPerProcess,
  parameter int FRAME_SLOTS       = FrameSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  input  logic [3:0]  page_log2_i,
  input  logic [6:0]  frames_i,
  input  logic [2:0]  process_id_i,
  input  logic [19:0] virtual_address_i,
  input  logic [31:0] access_time_i,
  output logic        page_hit_o,
  output logic [17:0] physical_address_o,
  output logic [5:0]  frame_number_o,
  output logic        victim_valid_o,
  output logic [2:0]  victim_process_o,
  output logic [7:0]  victim_page_o,
  output logic        address_error_o,
  output logic [31:0] hit_count_o,
  output logic [31:0] fault_count_o
);

  localparam int PgW   = (PAGES_PER_PROCESS > 1) ? $clog2(PAGES_PER_PROCESS) : 1;
  localparam int PidW  = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
  localparam int FrW   = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int PtD   = NUM_PROCESSES * PAGES_PER_PROCESS;
  localparam int PtAW  = (PtD > 1) ? $clog2(PtD) : 1;
  localparam int CntW  = $clog2(FRAME_SLOTS + 1);
  localparam int OwnW  = 1 + PidW + PgW;

  // page table: {present, frame}, cleared by a sweep after reset
  logic [FrW:0]    pt_mem [PtD];
  logic [FrW:0]    pt_rd_q;
  logic [PtAW:0]   clr_q;
  // frame owner: valid bits in flops, owner/page in a memory
  logic [FRAME_SLOTS-1:0] fvalid_q;
  logic [OwnW-2:0] own_mem [FRAME_SLOTS];
  logic [OwnW-2:0] own_rd_q;
  logic [31:0]     lt_mem [FRAME_SLOTS];
  logic [31:0]     lt_rd_q;

  logic [2:0]  pid_q;
  logic [19:0] va_q;
  logic [31:0] time_q;
  logic [3:0]  sh_q;
  logic [19:0] page_full;
  logic [PgW-1:0]  page;
  logic [PtAW-1:0] pt_addr;
  logic            err;

  logic [15:0]     lfsr_q;
  logic [31:0]     hits_q, faults_q;
  logic [CntW-1:0] nfr;
  logic [CntW-1:0] scan_q;
  logic [FrW:0]    scan_rd_q;   // index whose load time is in lt_rd_q
  logic            scan_rd_v_q;
  logic [FrW-1:0]  best_q;
  logic [31:0]     best_t_q;
  logic [FrW-1:0]  frame_q;
  logic            hit_q, vv_q;
  logic [15:0]     lfsr_nx;
  logic [15:0]     rnd_mod;

  assign page_full = va_q >> sh_q;
  assign page      = page_full[PgW-1:0];
  assign err = (32'(pid_q) >= 32'(NUM_PROCESSES)) ||
               (32'(page_full) >= 32'(PAGES_PER_PROCESS));
  assign pt_addr = PtAW'(32'(pid_q) * 32'(PAGES_PER_PROCESS) + 32'(page));

  always_comb begin
    nfr = CntW'(FRAME_SLOTS);
    if (frames_i == 7'd0) nfr = CntW'(1);
    else if (32'(frames_i) < 32'(FRAME_SLOTS)) nfr = CntW'(frames_i);
  end

  // lfsr step; the new value is reduced modulo the frame count below
  assign lfsr_nx = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};

  // modulo unit: restoring reduction, one bit per cycle
  logic [4:0]  mod_cnt_q;
  logic [15:0] mod_rem_q;
  logic        mod_busy_q;
  logic [31:0] mod_sub;
  assign mod_sub = {16'd0, mod_rem_q} - ((32'(nfr)) << mod_cnt_q);
  assign rnd_mod = mod_rem_q;

  // input capture, sequencing registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pid_q  <= process_id_i;
      va_q   <= virtual_address_i;
      time_q <= access_time_i;
      sh_q   <= (page_log2_i > MaxLog2) ? MaxLog2 : page_log2_i;
    end
  end

  // page table memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) pt_mem[clr_q[PtAW-1:0]] <= '0;
    else if (cmd_i.evict && vv_q && 32'(own_rd_q[OwnW-2 -: PidW]) < 32'(NUM_PROCESSES))
      pt_mem[PtAW'(32'(own_rd_q[OwnW-2 -: PidW]) * 32'(PAGES_PER_PROCESS)
             + 32'(own_rd_q[PgW-1:0]))] <= '0;
    else if (cmd_i.commit) pt_mem[pt_addr] <= {1'b1, frame_q};
    if (cmd_i.pt_read) pt_rd_q <= pt_mem[pt_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clear_step && !sts_o.clear_done) clr_q <= clr_q + 1'b1;
  end

  // frame owner and load time memories; victim owner held until the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      own_mem[frame_q] <= {PidW'(pid_q), page};
      lt_mem[frame_q]  <= time_q;
    end
    if (cmd_i.own_read) own_rd_q <= own_mem[frame_q];
    lt_rd_q  <= lt_mem[scan_q[FrW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fvalid_q <= '0;
      lfsr_q   <= LfsrSeed;
      hits_q   <= '0;
      faults_q <= '0;
      mod_busy_q <= 1'b0;
      mod_cnt_q  <= '0;
    end else begin
      if (cmd_i.commit) begin
        fvalid_q[frame_q] <= 1'b1;
        faults_q <= faults_q + 32'd1;
      end
      if (cmd_i.scan_start && pt_rd_q[FrW] && !vv_q) hits_q <= hits_q + 32'd1;
      if (cmd_i.pick_random) begin
        lfsr_q     <= lfsr_nx;
        mod_busy_q <= 1'b1;
        mod_cnt_q  <= 5'd15;
      end else if (mod_busy_q) begin
        if (mod_cnt_q == 5'd0) mod_busy_q <= 1'b0;
        else mod_cnt_q <= mod_cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pick_random) mod_rem_q <= lfsr_nx;
    else if (mod_busy_q && !mod_sub[31]) mod_rem_q <= mod_sub[15:0];
  end

  // scan: free frame search then FIFO min search
  always_ff @(posedge clk_i) begin
    if (cmd_i.pt_read) hit_q <= 1'b0;
    if (cmd_i.scan_start && !cmd_i.pick_random) begin
      scan_q      <= '0;
      scan_rd_v_q <= 1'b0;
      best_q      <= '0;
      best_t_q    <= '1;
      if (pt_rd_q[FrW] && !vv_q) begin
        hit_q   <= 1'b1;
        frame_q <= pt_rd_q[FrW-1:0];
      end
    end
    if (cmd_i.scan_step) begin
      scan_q      <= scan_q + 1'b1;
      scan_rd_v_q <= 1'b1;
      scan_rd_q   <= {1'b0, scan_q[FrW-1:0]};
      if (!fvalid_q[scan_q[FrW-1:0]]) frame_q <= scan_q[FrW-1:0];
      if (scan_rd_v_q && lt_rd_q < best_t_q) begin
        best_t_q <= lt_rd_q;
        best_q   <= scan_rd_q[FrW-1:0];
      end
    end
    if (cmd_i.fifo_pick) begin
      vv_q    <= 1'b1;
      frame_q <= (scan_rd_v_q && lt_rd_q < best_t_q) ? scan_rd_q[FrW-1:0] : best_q;
    end
    if (cmd_i.capture) vv_q <= 1'b0;
    if (cmd_i.pick_random) vv_q <= 1'b1;
    if (cmd_i.rand_load) frame_q <= rnd_mod[FrW-1:0];
  end

  // free_found when scanned frame empty; last when scan reaches the last managed frame
  assign sts_o.clear_done = (32'(clr_q) >= 32'(PtD));
  assign sts_o.addr_err   = err;
  assign sts_o.pt_present = pt_rd_q[FrW];
  assign sts_o.free_found = cmd_i.scan_step && !vv_q && !fvalid_q[scan_q[FrW-1:0]]
                            && (scan_q < nfr);
  assign sts_o.scan_last  = (scan_q == nfr - CntW'(1));
  assign sts_o.mod_busy   = mod_busy_q;

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      page_hit_o         <= !err && hit_q;
      address_error_o    <= err;
      frame_number_o     <= err ? 6'd0 : 6'(frame_q);
      physical_address_o <= err ? 18'd0 :
                            18'((32'(frame_q) << sh_q) + 32'(va_q & ~(20'hFFFFF << sh_q)));
      victim_valid_o     <= !err && !hit_q && vv_q;
      victim_process_o   <= (!err && !hit_q && vv_q) ? 3'(own_rd_q[OwnW-2 -: PidW]) : 3'd0;
      victim_page_o      <= (!err && !hit_q && vv_q) ? 8'(own_rd_q[PgW-1:0]) : 8'd0;
      hit_count_o        <= hits_q;
      fault_count_o      <= faults_q;
    end
  end

endmodule

// File: rtl/paged_address_translator_unit.sv
// Channel | Role | Moves
// acc     | sink   | access item: process_id, virtual_address, access_time
// res     | source | result item: hit, physical address, victim, counters
// cfg     | sink   | register write: index, data
// A fault scans the managed frames for a free one; a FIFO eviction scans
// their load times and a random eviction waits on the modulo unit.
// After reset the page table is swept clear, one entry a cycle, before the
// first item is taken. One item is in flight at a time; a result waiting on
// res stalls the next item.
module paged_address_translator_unit import pat_pkg::*; #(
  parameter int NUM_PROCESSES     = NumProcesses,
  parameter int PAGES_PER_PROCESS = PagesPerProcess,
  parameter int FRAME_SLOTS       = FrameSlots
) (
  input logic       clk_i,
  input logic       rst_ni,
  pat_access_if.sink  acc,
  pat_result_if.source res,
  pat_cfg_if.sink   cfg
);

  logic [3:0] page_log2_q;
  logic       repl_mode_q;
  logic [6:0] frames_q;
  dp_cmd_t    cmd;
  dp_sts_t    sts;
  cfg_idx_e   cidx;

  assign cfg.ready = 1'b1;
  assign cidx = cfg_idx_e'(cfg.index);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_log2_q <= PageLog2Rst;
      repl_mode_q <= 1'b0;
      frames_q    <= FramesRst;
    end else if (cfg.valid) begin
      case (cidx)
        CFG_PAGE_LOG2: page_log2_q <= cfg.data[3:0];
        CFG_REPL_MODE: repl_mode_q <= cfg.data[0];
        CFG_FRAMES:    frames_q    <= cfg.data[6:0];
        default:       frames_q    <= frames_q;
      endcase
    end
  end

  pat_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (acc.valid), .in_ready_o (acc.ready),
    .out_valid_o(res.valid), .out_ready_i(res.ready),
    .repl_mode_i(repl_mode_q), .sts_i(sts), .cmd_o(cmd)
  );

  pat_dpath #(
    .NUM_PROCESSES(NUM_PROCESSES), .PAGES_PER_PROCESS(PAGES_PER_PROCESS),
    .FRAME_SLOTS(FRAME_SLOTS)
  ) u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .page_log2_i(page_log2_q), .frames_i(frames_q),
    .process_id_i(acc.process_id), .virtual_address_i(acc.virtual_address),
    .access_time_i(acc.access_time),
    .page_hit_o(res.page_hit), .physical_address_o(res.physical_address),
    .frame_number_o(res.frame_number), .victim_valid_o(res.victim_valid),
    .victim_process_o(res.victim_process), .victim_page_o(res.victim_page),
    .address_error_o(res.address_error), .hit_count_o(res.hit_count),
    .fault_count_o(res.fault_count)
  );

`ifndef ASSERT_OFF
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.commit && cmd.evict)) else $error("commit and evict together");
  a_hit_no_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && res.page_hit |-> !res.victim_valid) else $error("hit with victim");
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && res.address_error |-> !res.page_hit) else $error("error with hit");
`endif

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import pat_pkg::*;

  // one translation result, field by field
  typedef struct packed {
    logic        page_hit;
    logic [17:0] physical_address;
    logic [5:0]  frame_number;
    logic        victim_valid;
    logic [2:0]  victim_process;
    logic [7:0]  victim_page;
    logic        address_error;
    logic [31:0] hit_count;
    logic [31:0] fault_count;
  } xlat_t;

  // directed access, with a hand-written result where one is given
  typedef struct {
    int unsigned pid;
    int unsigned va;
    int unsigned stamp;
    bit          typed;
    xlat_t       want;
  } access_row_t;

  typedef struct {
    int unsigned log2;
    int unsigned mode;
    int unsigned frames;
    int          items;
  } phase_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pat_access_if acc_if();
  pat_result_if res_if();
  pat_cfg_if    cfg_if();

  paged_address_translator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc    (acc_if),
    .res    (res_if),
    .cfg    (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the translator state
  bit          pt_present [NumProcesses*PagesPerProcess];
  int unsigned pt_frame   [NumProcesses*PagesPerProcess];
  bit          frame_held [FrameSlots];
  int unsigned frame_pid  [FrameSlots];
  int unsigned frame_vpage[FrameSlots];
  int unsigned frame_stamp[FrameSlots];
  logic [15:0] lfsr_q = LfsrSeed;
  logic [31:0] hits_q = '0;
  logic [31:0] faults_q = '0;
  int unsigned page_log2_q = PageLog2Rst;
  int unsigned repl_mode_q = 0;
  int unsigned frames_q = FramesRst;

  xlat_t pending_results[$];
  int    errors = 0;
  int    burst_left = 0;

  task automatic translate(input int unsigned pid, input int unsigned va,
                           input int unsigned stamp, output xlat_t r);
    int unsigned sh, pg, off, n, fr, idx, vidx;
    bit found;
    r = '0;
    fr = 0;
    sh = (page_log2_q > MaxLog2) ? MaxLog2 : page_log2_q;
    pg = va >> sh;
    off = va & ((32'd1 << sh) - 1);
    if (pid >= NumProcesses || pg >= PagesPerProcess) begin
      r.address_error = 1'b1;
    end else begin
      idx = pid * PagesPerProcess + pg;
      if (pt_present[idx]) begin
        r.page_hit = 1'b1;
        fr = pt_frame[idx];
        hits_q++;
      end else begin
        n = (frames_q < 1) ? 1 : (frames_q > FrameSlots ? FrameSlots : frames_q);
        found = 0;
        for (int i = 0; i < n; i++) begin
          if (!found && !frame_held[i]) begin
            fr = i;
            found = 1;
          end
        end
        // all managed frames full: evict
        if (!found) begin
          if (repl_mode_q[0]) begin
            lfsr_q = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
            fr = lfsr_q % n;
          end else begin
            fr = 0;
            for (int i = 1; i < n; i++)
              if (frame_stamp[i] < frame_stamp[fr]) fr = i;
          end
          r.victim_valid = 1'b1;
          r.victim_process = 3'(frame_pid[fr]);
          r.victim_page = 8'(frame_vpage[fr]);
          vidx = frame_pid[fr] * PagesPerProcess + frame_vpage[fr];
          pt_present[vidx] = 0;
          pt_frame[vidx] = 0;
        end
        frame_held[fr] = 1;
        frame_pid[fr] = pid;
        frame_vpage[fr] = pg;
        frame_stamp[fr] = stamp;
        pt_present[idx] = 1;
        pt_frame[idx] = fr;
        faults_q++;
      end
      r.frame_number = 6'(fr);
      r.physical_address = 18'((fr << sh) + off);
    end
    r.hit_count = hits_q;
    r.fault_count = faults_q;
  endtask

  task automatic report(input string field, input longint got, input longint want);
    errors++;
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, field, got, want);
  endtask

  // send one access, bursts separated by random gaps
  task automatic send_access(input access_row_t row);
    xlat_t r;
    if (burst_left == 0) begin
      acc_if.valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
    end
    acc_if.valid = 1'b1;
    acc_if.process_id = 3'(row.pid);
    acc_if.virtual_address = 20'(row.va);
    acc_if.access_time = row.stamp;
    do @(posedge clk_i); while (!acc_if.ready);
    translate(row.pid, row.va, row.stamp, r);
    pending_results.push_back(row.typed ? row.want : r);
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned value);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = value;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_PAGE_LOG2: page_log2_q = value & 4'hF;
      CFG_REPL_MODE: repl_mode_q = value & 1;
      CFG_FRAMES:    frames_q = value & 7'h7F;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic drain;
    acc_if.valid = 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // receiver stall pattern, reloaded after each pass through its 64 bits
  logic [63:0] stall_pat = '1;
  int          stall_pos = 0;
  initial res_if.ready = 1'b0;
  always @(negedge clk_i) begin
    if (stall_pos == 63) begin
      stall_pat <= ($urandom_range(0, 3) == 0) ? '1 : {$urandom, $urandom};
    end
    stall_pos <= (stall_pos + 1) % 64;
    res_if.ready <= stall_pat[stall_pos];
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    xlat_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        want = pending_results.pop_front();
        if (res_if.page_hit !== want.page_hit)
          report("page_hit", res_if.page_hit, want.page_hit);
        if (res_if.physical_address !== want.physical_address)
          report("physical_address", res_if.physical_address, want.physical_address);
        if (res_if.frame_number !== want.frame_number)
          report("frame_number", res_if.frame_number, want.frame_number);
        if (res_if.victim_valid !== want.victim_valid)
          report("victim_valid", res_if.victim_valid, want.victim_valid);
        if (res_if.victim_process !== want.victim_process)
          report("victim_process", res_if.victim_process, want.victim_process);
        if (res_if.victim_page !== want.victim_page)
          report("victim_page", res_if.victim_page, want.victim_page);
        if (res_if.address_error !== want.address_error)
          report("address_error", res_if.address_error, want.address_error);
        if (res_if.hit_count !== want.hit_count)
          report("hit_count", res_if.hit_count, want.hit_count);
        if (res_if.fault_count !== want.fault_count)
          report("fault_count", res_if.fault_count, want.fault_count);
      end
    end
  end

  // directed accesses under the reset configuration (256-byte pages, FIFO)
  access_row_t directed[$] = '{
    '{0, 'h00000, 100,          1, '{0, 0,      0, 0, 0, 0, 0, 0, 1}},
    '{0, 'h000FF, 101,          1, '{1, 'hFF,   0, 0, 0, 0, 0, 1, 1}},
    '{7, 'h0FFFF, 0,            1, '{0, 'h1FF,  1, 0, 0, 0, 0, 1, 2}},
    '{3, 'hFFFFF, 5,            1, '{0, 0,      0, 0, 0, 0, 1, 1, 2}},
    '{0, 'h00100, 'hFFFFFFFF,   1, '{0, 'h200,  2, 0, 0, 0, 0, 1, 3}},
    '{7, 'h0FF00, 7,            1, '{1, 'h100,  1, 0, 0, 0, 0, 2, 3}},
    '{5, 'h10000, 9,            1, '{0, 0,      0, 0, 0, 0, 1, 2, 3}},
    '{4, 'h0ABCD, 200,          0, '0},
    '{1, 'h05A5A, 300,          0, '0},
    '{6, 'h0C3C3, 0,            0, '0},
    '{0, 'h00001, 400,          0, '0},
    '{4, 'h0AB00, 401,          0, '0}
  };

  // settings walked by the random part, extremes included
  phase_t phases[$] = '{
    '{8,  0, 64,  150}, '{15, 0, 0,   120}, '{0, 1, 1,   120},
    '{12, 1, 127, 150}, '{4,  0, 3,   150}, '{13, 1, 5,  150},
    '{10, 0, 64,  150}, '{6,  1, 64,  150}, '{2, 0, 8,   150},
    '{9,  1, 2,   150}
  };

  initial begin
    access_row_t row;
    int unsigned sh, max_page, pool, pg, clock_now;
    acc_if.valid = 1'b0;
    acc_if.process_id = '0;
    acc_if.virtual_address = '0;
    acc_if.access_time = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_NONE;
    cfg_if.data = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) send_access(directed[i]);

    clock_now = 1000;
    foreach (phases[p]) begin
      drain();
      write_reg(CFG_PAGE_LOG2, phases[p].log2);
      write_reg(CFG_REPL_MODE, phases[p].mode);
      write_reg(CFG_FRAMES, phases[p].frames);
      sh = (page_log2_q > MaxLog2) ? MaxLog2 : page_log2_q;
      max_page = ((32'hFFFFF >> sh) < PagesPerProcess - 1) ?
                 (32'hFFFFF >> sh) : PagesPerProcess - 1;
      pool = (frames_q < 1 ? 1 : frames_q) / 4 + 2;
      for (int k = 0; k < phases[p].items; k++) begin
        row.typed = 0;
        row.want = '0;
        row.pid = $urandom_range(0, 7);
        if ($urandom_range(0, 9) < 8) begin
          // well-formed access into a small working set
          pg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, max_page) :
               $urandom_range(0, pool < max_page ? pool : max_page);
          row.pid = row.pid & ($urandom_range(0, 1) ? 3'd1 : 3'd7);
          row.va = ((pg << sh) | ($urandom & ((32'd1 << sh) - 1))) & 32'hFFFFF;
        end else begin
          row.va = $urandom & 32'hFFFFF;
        end
        case ($urandom_range(0, 7))
          0: row.stamp = $urandom;
          1: row.stamp = clock_now;
          default: begin
            clock_now += $urandom_range(1, 50);
            row.stamp = clock_now;
          end
        endcase
        send_access(row);
      end
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
